/* rtl/fpsa_pkg.sv */
`timescale 1ns / 1ps
package fpsa_pkg;

  localparam int unsigned FFT_SIZE = 1024;
  localparam int unsigned LOG_N    = $clog2(FFT_SIZE);
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned SMP_W    = 16;
  localparam int unsigned XF_W     = 29;
  localparam int unsigned TW_W     = 16;
  localparam int unsigned ACC_W    = 64;
  localparam int unsigned SQ_W     = 2 * XF_W;
  localparam int unsigned TW_OCT   = FFT_SIZE / 8;
  localparam int unsigned OCT_W    = $clog2(TW_OCT + 1);
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

  localparam logic [1:0] FMT_OFFSET = 2'd0;
  localparam logic [1:0] FMT_SIGNED = 2'd1;
  localparam logic [1:0] FMT_REAL   = 2'd2;

  localparam logic [1:0] CMD_PUSH     = 2'd0;
  localparam logic [1:0] CMD_READ     = 2'd1;
  localparam logic [1:0] CMD_READ_CLR = 2'd2;

  typedef struct packed {
    logic signed [XF_W-1:0] re;
    logic signed [XF_W-1:0] im;
  } cplx_t;

  typedef struct packed {
    logic             sat;
    logic [ACC_W-1:0] acc;
  } acc_entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    cplx_t            wdata;
    logic             re;
    logic [IDX_W-1:0] raddr_a;
    logic [IDX_W-1:0] raddr_b;
  } xram_req_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    acc_entry_t       wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } acc_req_t;

  typedef struct packed {
    logic mul_en;
    logic add_en;
  } bfly_ctrl_t;

  typedef struct packed {
    logic sq_en;
    logic pw_en;
  } pwr_ctrl_t;

  typedef logic [2*TW_W-1:0] tw_rom_t [0:TW_OCT];

  function automatic logic [IDX_W-1:0] bitrev(input logic [IDX_W-1:0] v);
    logic [IDX_W-1:0] r;
    for (int b = 0; b < IDX_W; b++) begin
      r[b] = v[IDX_W-1-b];
    end
    return r;
  endfunction

  // Rounded division by the Taylor series denominators.
  function automatic longint unsigned div_rnd(input longint unsigned t, input int unsigned sel);
    longint unsigned r;
    case (sel)
      0: r = (t + 1) / 2;
      1: r = (t + 6) / 12;
      2: r = (t + 15) / 30;
      3: r = (t + 28) / 56;
      4: r = (t + 45) / 90;
      5: r = (t + 3) / 6;
      6: r = (t + 10) / 20;
      7: r = (t + 21) / 42;
      8: r = (t + 36) / 72;
      default: r = (t + 55) / 110;
    endcase
    return r;
  endfunction

  function automatic longint taylor_q30(input longint unsigned x, input bit odd);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = odd ? x : (64'd1 << 30);
    sum  = longint'(term);
    for (int unsigned n = 1; n <= 5; n++) begin
      term = (term * x2 + (64'd1 << 29)) >> 30;
      term = div_rnd(term, odd ? n + 4 : n - 1);
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    return sum;
  endfunction

  function automatic logic signed [TW_W-1:0] to_q15(input longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    return TW_W'(r);
  endfunction

  function automatic tw_rom_t build_tw_rom();
    tw_rom_t         rom;
    longint unsigned x;
    for (int unsigned k = 0; k <= TW_OCT; k++) begin
      x = (longint'(k) * TWO_PI_Q30 + FFT_SIZE / 2) / FFT_SIZE;
      rom[k] = {to_q15(taylor_q30(x, 1'b0)), to_q15(taylor_q30(x, 1'b1))};
    end
    return rom;
  endfunction

  localparam tw_rom_t TW_ROM = build_tw_rom();

  // Twiddle W^k = c - j*s from the first-octant table by symmetry.
  function automatic logic [2*TW_W-1:0] tw_lookup(input logic [LOG_N-2:0] k);
    logic [IDX_W-1:0]       kk;
    logic [OCT_W-1:0]       idx;
    logic [2*TW_W-1:0]      e;
    logic signed [TW_W-1:0] ec;
    logic signed [TW_W-1:0] es;
    logic signed [TW_W-1:0] c;
    logic signed [TW_W-1:0] s;
    kk = {1'b0, k};
    if (kk <= IDX_W'(TW_OCT)) idx = OCT_W'(kk);
    else if (kk <= IDX_W'(2 * TW_OCT)) idx = OCT_W'(IDX_W'(2 * TW_OCT) - kk);
    else if (kk <= IDX_W'(3 * TW_OCT)) idx = OCT_W'(kk - IDX_W'(2 * TW_OCT));
    else idx = OCT_W'(IDX_W'(4 * TW_OCT) - kk);
    e  = TW_ROM[idx];
    ec = e[2*TW_W-1:TW_W];
    es = e[TW_W-1:0];
    if (kk <= IDX_W'(TW_OCT)) begin
      c = ec; s = es;
    end else if (kk <= IDX_W'(2 * TW_OCT)) begin
      c = es; s = ec;
    end else if (kk <= IDX_W'(3 * TW_OCT)) begin
      c = -es; s = ec;
    end else begin
      c = -ec; s = es;
    end
    return {c, s};
  endfunction

endpackage

/* rtl/fpsa_xram.sv */
`timescale 1ns / 1ps
module fpsa_xram (
  input  logic               clk_i,
  input  fpsa_pkg::xram_req_t req_i,
  output fpsa_pkg::cplx_t    rdata_a_o,
  output fpsa_pkg::cplx_t    rdata_b_o
);
  import fpsa_pkg::*;

  cplx_t mem [FFT_SIZE];
  cplx_t rdata_a_q;
  cplx_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_a_q <= mem[req_i.raddr_a];
      rdata_b_q <= mem[req_i.raddr_b];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

/* rtl/fpsa_acc_ram.sv */
`timescale 1ns / 1ps
module fpsa_acc_ram (
  input  logic                 clk_i,
  input  fpsa_pkg::acc_req_t   req_i,
  output fpsa_pkg::acc_entry_t rdata_o
);
  import fpsa_pkg::*;

  acc_entry_t mem [FFT_SIZE];
  acc_entry_t rdata_q;

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/fpsa_bfly.sv */
`timescale 1ns / 1ps
module fpsa_bfly (
  input  logic                             clk_i,
  input  fpsa_pkg::bfly_ctrl_t             ctrl_i,
  input  fpsa_pkg::cplx_t                  a_i,
  input  fpsa_pkg::cplx_t                  b_i,
  input  logic signed [fpsa_pkg::TW_W-1:0] tw_c_i,
  input  logic signed [fpsa_pkg::TW_W-1:0] tw_s_i,
  output fpsa_pkg::cplx_t                  a_o,
  output fpsa_pkg::cplx_t                  b_o
);
  import fpsa_pkg::*;

  localparam int unsigned PW = XF_W + TW_W;
  localparam logic signed [PW:0] RND = 1 <<< 14;

  cplx_t                a_q;
  logic signed [PW-1:0] p_rc_q;
  logic signed [PW-1:0] p_is_q;
  logic signed [PW-1:0] p_ic_q;
  logic signed [PW-1:0] p_rs_q;
  cplx_t                a_res_q;
  cplx_t                b_res_q;
  logic signed [PW:0]   sum_r;
  logic signed [PW:0]   sum_i;
  logic signed [PW-15:0] tr;
  logic signed [PW-15:0] ti;
  cplx_t                a_d;
  cplx_t                b_d;

  // Twiddle products are rounded half up to the sample scale.
  always_comb begin
    sum_r  = p_rc_q + p_is_q + RND;
    sum_i  = p_ic_q - p_rs_q + RND;
    tr     = sum_r[PW:15];
    ti     = sum_i[PW:15];
    a_d.re = XF_W'(a_q.re + tr);
    a_d.im = XF_W'(a_q.im + ti);
    b_d.re = XF_W'(a_q.re - tr);
    b_d.im = XF_W'(a_q.im - ti);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      a_q    <= a_i;
      p_rc_q <= b_i.re * tw_c_i;
      p_is_q <= b_i.im * tw_s_i;
      p_ic_q <= b_i.im * tw_c_i;
      p_rs_q <= b_i.re * tw_s_i;
    end
    if (ctrl_i.add_en) begin
      a_res_q <= a_d;
      b_res_q <= b_d;
    end
  end

  assign a_o = a_res_q;
  assign b_o = b_res_q;

endmodule

/* rtl/fpsa_pwr.sv */
`timescale 1ns / 1ps
module fpsa_pwr (
  input  logic                 clk_i,
  input  fpsa_pkg::pwr_ctrl_t  ctrl_i,
  input  fpsa_pkg::cplx_t      x_i,
  input  fpsa_pkg::acc_entry_t acc_i,
  output fpsa_pkg::acc_entry_t acc_o
);
  import fpsa_pkg::*;

  logic signed [SQ_W-1:0] sq_r_q;
  logic signed [SQ_W-1:0] sq_i_q;
  logic [SQ_W-1:0]        pw_q;
  logic [ACC_W:0]         sum;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sq_en) begin
      sq_r_q <= x_i.re * x_i.re;
      sq_i_q <= x_i.im * x_i.im;
    end
    if (ctrl_i.pw_en) begin
      pw_q <= SQ_W'($unsigned(sq_r_q) + $unsigned(sq_i_q));
    end
  end

  // A carry out of the accumulator pins it at full scale and marks it.
  always_comb begin
    sum = {1'b0, acc_i.acc} + (ACC_W + 1)'(pw_q);
    if (sum[ACC_W]) begin
      acc_o.sat = 1'b1;
      acc_o.acc = '1;
    end else begin
      acc_o.sat = acc_i.sat;
      acc_o.acc = sum[ACC_W-1:0];
    end
  end

endmodule

/* rtl/fft_power_spectrum_accumulator.sv */
`timescale 1ns / 1ps
// Power spectrum accumulator over 1024-point frames, stored in fftshift order.
// Requests enter on start_i with cmd_i; a request is taken when start_i is high
// and busy_o is low. A push request stores one complex sample. A
// read request (cmd 1, or cmd 2 which also clears the bin) returns its result
// on the cycle after acceptance: valid_o is high for exactly that one cycle with
// bin_position_o, power_o and saturated_o. The receiver cannot stall.
// The push that completes a frame starts the transform: the in-place radix-2
// FFT runs one butterfly at a time on the transform memory (read, multiply, add,
// two writes through its single write port), followed by power accumulation one
// bin at a time (read, square, sum, write). busy_o stays high through both, so
// pushes stall while a frame is processed; otherwise read requests can be taken
// back to back.
// After reset busy_o stays high while the accumulator memory is cleared one
// entry per cycle. input_format is written through cfg_we_i and cfg_wdata_i at
// any edge and is used for pushes only.
module fft_power_spectrum_accumulator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [1:0]                        cmd_i,
  input  logic signed [fpsa_pkg::SMP_W-1:0] sample_i_i,
  input  logic signed [fpsa_pkg::SMP_W-1:0] sample_q_i,
  input  logic [fpsa_pkg::IDX_W-1:0]        read_index_i,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_wdata_i,
  output logic                              valid_o,
  output logic [fpsa_pkg::IDX_W-1:0]        bin_position_o,
  output logic [fpsa_pkg::ACC_W-1:0]        power_o,
  output logic                              saturated_o
);
  import fpsa_pkg::*;

  localparam int unsigned STG_W = $clog2(LOG_N);

  typedef enum logic [10:0] {
    ST_CLEAR  = 11'b00000000001,
    ST_IDLE   = 11'b00000000010,
    ST_BF_RD  = 11'b00000000100,
    ST_BF_MUL = 11'b00000001000,
    ST_BF_ADD = 11'b00000010000,
    ST_BF_WA  = 11'b00000100000,
    ST_BF_WB  = 11'b00001000000,
    ST_AC_RD  = 11'b00010000000,
    ST_AC_SQ  = 11'b00100000000,
    ST_AC_PW  = 11'b01000000000,
    ST_AC_WR  = 11'b10000000000
  } state_e;

  state_e           state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic [STG_W-1:0] stage_q, stage_d;
  logic [IDX_W-1:0] fill_q, fill_d;
  logic [1:0]       fmt_q;
  logic             rsp_valid_q, rsp_valid_d;
  logic [IDX_W-1:0] rsp_pos_q;

  logic             accept;
  logic [LOG_N-2:0] j;
  logic [IDX_W-1:0] half, mask, mask2, addr_a, addr_b, src_idx;
  logic [LOG_N-2:0] m, k;
  logic [2*TW_W-1:0] tw;
  cplx_t            smp;
  cplx_t            xr_a, xr_b, bf_a, bf_b;
  xram_req_t        xreq;
  acc_req_t         areq;
  acc_entry_t       acc_rd, acc_new;
  bfly_ctrl_t       bctrl;
  pwr_ctrl_t        pctrl;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  // Butterfly addressing for the current stage and butterfly number.
  always_comb begin
    j      = cnt_q[LOG_N-2:0];
    half   = IDX_W'(1) << stage_q;
    mask   = half - IDX_W'(1);
    mask2  = {mask[IDX_W-2:0], 1'b1};
    addr_a = ({j, 1'b0} & ~mask2) | ({1'b0, j} & mask);
    addr_b = addr_a | half;
    m      = j & mask[LOG_N-2:0];
    k      = (LOG_N - 1)'(m << (STG_W'(LOG_N - 1) - stage_q));
    tw     = tw_lookup(k);
    // Position p holds bin p + N/2; the DC position takes the top bin instead.
    src_idx = cnt_q ^ (IDX_W'(1) << (LOG_N - 1));
    if (src_idx == '0) src_idx = '1;
  end

  always_comb begin
    case (fmt_q)
      FMT_OFFSET: begin
        smp.re = XF_W'($signed({~sample_i_i[7], sample_i_i[6:0]}));
        smp.im = XF_W'($signed({~sample_q_i[7], sample_q_i[6:0]}));
      end
      FMT_REAL: begin
        smp.re = XF_W'(sample_i_i);
        smp.im = '0;
      end
      default: begin
        smp.re = XF_W'(sample_i_i);
        smp.im = XF_W'(sample_q_i);
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    stage_d     = stage_q;
    fill_d      = fill_q;
    rsp_valid_d = 1'b0;
    xreq        = '0;
    areq        = '0;
    bctrl       = '0;
    pctrl       = '0;
    unique case (state_q)
      ST_CLEAR: begin
        areq.we    = 1'b1;
        areq.waddr = cnt_q;
        cnt_d      = cnt_q + IDX_W'(1);
        if (cnt_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (cmd_i)
            CMD_PUSH: begin
              // Samples land in bit-reversed order, ready for the butterflies.
              xreq.we    = 1'b1;
              xreq.waddr = bitrev(fill_q);
              xreq.wdata = smp;
              fill_d     = fill_q + IDX_W'(1);
              if (fill_q == '1) begin
                state_d = ST_BF_RD;
                cnt_d   = '0;
                stage_d = '0;
              end
            end
            CMD_READ, CMD_READ_CLR: begin
              areq.re     = 1'b1;
              areq.raddr  = read_index_i;
              areq.we     = (cmd_i == CMD_READ_CLR);
              areq.waddr  = read_index_i;
              rsp_valid_d = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_BF_RD: begin
        xreq.re      = 1'b1;
        xreq.raddr_a = addr_a;
        xreq.raddr_b = addr_b;
        state_d      = ST_BF_MUL;
      end
      ST_BF_MUL: begin
        bctrl.mul_en = 1'b1;
        state_d      = ST_BF_ADD;
      end
      ST_BF_ADD: begin
        bctrl.add_en = 1'b1;
        state_d      = ST_BF_WA;
      end
      ST_BF_WA: begin
        xreq.we    = 1'b1;
        xreq.waddr = addr_a;
        xreq.wdata = bf_a;
        state_d    = ST_BF_WB;
      end
      ST_BF_WB: begin
        xreq.we    = 1'b1;
        xreq.waddr = addr_b;
        xreq.wdata = bf_b;
        state_d    = ST_BF_RD;
        if (j == '1) begin
          cnt_d = '0;
          if (stage_q == STG_W'(LOG_N - 1)) state_d = ST_AC_RD;
          else stage_d = stage_q + STG_W'(1);
        end else begin
          cnt_d = cnt_q + IDX_W'(1);
        end
      end
      ST_AC_RD: begin
        xreq.re      = 1'b1;
        xreq.raddr_a = src_idx;
        areq.re      = 1'b1;
        areq.raddr   = cnt_q;
        state_d      = ST_AC_SQ;
      end
      ST_AC_SQ: begin
        pctrl.sq_en = 1'b1;
        state_d     = ST_AC_PW;
      end
      ST_AC_PW: begin
        pctrl.pw_en = 1'b1;
        state_d     = ST_AC_WR;
      end
      ST_AC_WR: begin
        areq.we    = 1'b1;
        areq.waddr = cnt_q;
        areq.wdata = acc_new;
        cnt_d      = cnt_q + IDX_W'(1);
        state_d    = (cnt_q == '1) ? ST_IDLE : ST_AC_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      stage_q     <= '0;
      fill_q      <= '0;
      fmt_q       <= FMT_OFFSET;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      stage_q     <= stage_d;
      fill_q      <= fill_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_we_i) fmt_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_valid_d) rsp_pos_q <= read_index_i;
  end

  fpsa_xram u_xram (
    .clk_i     (clk_i),
    .req_i     (xreq),
    .rdata_a_o (xr_a),
    .rdata_b_o (xr_b)
  );

  fpsa_bfly u_bfly (
    .clk_i  (clk_i),
    .ctrl_i (bctrl),
    .a_i    (xr_a),
    .b_i    (xr_b),
    .tw_c_i (tw[2*TW_W-1:TW_W]),
    .tw_s_i (tw[TW_W-1:0]),
    .a_o    (bf_a),
    .b_o    (bf_b)
  );

  fpsa_acc_ram u_acc_ram (
    .clk_i   (clk_i),
    .req_i   (areq),
    .rdata_o (acc_rd)
  );

  fpsa_pwr u_pwr (
    .clk_i  (clk_i),
    .ctrl_i (pctrl),
    .x_i    (xr_a),
    .acc_i  (acc_rd),
    .acc_o  (acc_new)
  );

  assign valid_o        = rsp_valid_q;
  assign bin_position_o = rsp_pos_q;
  assign power_o        = acc_rd.acc;
  assign saturated_o    = acc_rd.sat;

endmodule

/* sim/tb_spectrum_checker.sv */
`timescale 1ns / 1ps
module tb_spectrum_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              busy_o,
  input  logic [1:0]                        cmd_i,
  input  logic signed [fpsa_pkg::SMP_W-1:0] sample_i_i,
  input  logic signed [fpsa_pkg::SMP_W-1:0] sample_q_i,
  input  logic [fpsa_pkg::IDX_W-1:0]        read_index_i,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_wdata_i,
  input  logic                              valid_o,
  input  logic [fpsa_pkg::IDX_W-1:0]        bin_position_o,
  input  logic [fpsa_pkg::ACC_W-1:0]        power_o,
  input  logic                              saturated_o,
  output int                                mismatches_o,
  output int                                pending_o
);
  import fpsa_pkg::*;

  typedef struct {
    logic [IDX_W-1:0] pos;
    logic [ACC_W-1:0] pwr;
    logic             sat;
  } bin_read_t;

  bin_read_t        bin_reads_q[$];
  logic [1:0]       fmt;
  int               frame_re[FFT_SIZE];
  int               frame_im[FFT_SIZE];
  longint           spec_re[FFT_SIZE];
  longint           spec_im[FFT_SIZE];
  logic [ACC_W-1:0] power_acc[FFT_SIZE];
  logic             sat_mark[FFT_SIZE];
  int               fill;
  longint           cos_q15[FFT_SIZE/2];
  longint           sin_q15[FFT_SIZE/2];

  assign pending_o = bin_reads_q.size();

  // Series for sin or cos in Q30 on the first octant.
  function automatic longint series_q30(longint unsigned x, bit odd);
    longint unsigned x2, term, d;
    longint          sum;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = odd ? x : (64'd1 << 30);
    sum  = longint'(term);
    for (int unsigned n = 1; n <= 5; n++) begin
      d    = odd ? (2 * n) * (2 * n + 1) : (2 * n - 1) * (2 * n);
      term = (term * x2 + (64'd1 << 29)) >> 30;
      term = (term + d / 2) / d;
      if (n & 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    return sum;
  endfunction

  function automatic longint q30_to_q15(longint v);
    longint r;
    r = (v + 16384) >>> 15;
    return (r > 32767) ? 32767 : r;
  endfunction

  function automatic void octant_pair(int unsigned k, output longint c, output longint s);
    longint unsigned x;
    x = (longint'(k) * TWO_PI_Q30 + FFT_SIZE / 2) / FFT_SIZE;
    c = q30_to_q15(series_q30(x, 1'b0));
    s = q30_to_q15(series_q30(x, 1'b1));
  endfunction

  function automatic longint round_q15(longint v);
    return (v + 16384) >>> 15;
  endfunction

  function automatic void transform_frame();
    int unsigned j, half, stride, k;
    longint      tr, ti, ar, ai, br, bi;
    for (int unsigned i = 0; i < FFT_SIZE; i++) begin
      j = 0;
      for (int b = 0; b < LOG_N; b++) j |= ((i >> b) & 1) << (LOG_N - 1 - b);
      spec_re[j] = frame_re[i];
      spec_im[j] = frame_im[i];
    end
    for (int unsigned len = 2; len <= FFT_SIZE; len <<= 1) begin
      half   = len / 2;
      stride = FFT_SIZE / len;
      for (int unsigned base = 0; base < FFT_SIZE; base += len) begin
        for (int unsigned m = 0; m < half; m++) begin
          k  = (m * stride) & (FFT_SIZE / 2 - 1);
          br = spec_re[base + m + half];
          bi = spec_im[base + m + half];
          tr = round_q15(br * cos_q15[k] + bi * sin_q15[k]);
          ti = round_q15(bi * cos_q15[k] - br * sin_q15[k]);
          ar = spec_re[base + m];
          ai = spec_im[base + m];
          spec_re[base + m]        = ar + tr;
          spec_im[base + m]        = ai + ti;
          spec_re[base + m + half] = ar - tr;
          spec_im[base + m + half] = ai - ti;
        end
      end
    end
  endfunction

  function automatic void accumulate_power();
    int unsigned      bin;
    longint unsigned  mr, mi, pw;
    for (int unsigned p = 0; p < FFT_SIZE; p++) begin
      bin = (p + FFT_SIZE / 2) & (FFT_SIZE - 1);
      // The DC slot takes the power of the bin just below it.
      if (bin == 0) bin = FFT_SIZE - 1;
      mr = (spec_re[bin] < 0) ? -spec_re[bin] : spec_re[bin];
      mi = (spec_im[bin] < 0) ? -spec_im[bin] : spec_im[bin];
      pw = mr * mr + mi * mi;
      if (pw > ~power_acc[p]) begin
        power_acc[p] = '1;
        sat_mark[p]  = 1'b1;
      end else begin
        power_acc[p] = power_acc[p] + pw;
      end
    end
  endfunction

  initial begin
    longint c, s;
    mismatches_o = 0;
    fmt          = FMT_OFFSET;
    fill         = 0;
    for (int i = 0; i < FFT_SIZE; i++) begin
      power_acc[i] = '0;
      sat_mark[i]  = 1'b0;
    end
    for (int unsigned k = 0; k < FFT_SIZE / 2; k++) begin
      if (k <= TW_OCT) begin
        octant_pair(k, c, s); cos_q15[k] = c; sin_q15[k] = s;
      end else if (k <= 2 * TW_OCT) begin
        octant_pair(2 * TW_OCT - k, c, s); cos_q15[k] = s; sin_q15[k] = c;
      end else if (k <= 3 * TW_OCT) begin
        octant_pair(k - 2 * TW_OCT, c, s); cos_q15[k] = -s; sin_q15[k] = c;
      end else begin
        octant_pair(4 * TW_OCT - k, c, s); cos_q15[k] = -c; sin_q15[k] = s;
      end
    end
  end

  always @(posedge clk_i) begin
    bin_read_t want;
    if (rst_ni) begin
      if (valid_o) begin
        if (bin_reads_q.size() == 0) begin
          $error("unexpected result at position %0d", bin_position_o);
          mismatches_o++;
        end else begin
          want = bin_reads_q.pop_front();
          if (bin_position_o !== want.pos) begin
            $error("bin_position: expected %0d, got %0d", want.pos, bin_position_o);
            mismatches_o++;
          end
          if (power_o !== want.pwr) begin
            $error("power: expected %0d, got %0d", want.pwr, power_o);
            mismatches_o++;
          end
          if (saturated_o !== want.sat) begin
            $error("saturated: expected %0d, got %0d", want.sat, saturated_o);
            mismatches_o++;
          end
        end
      end
      if (cfg_we_i) fmt = cfg_wdata_i;
      if (start_i && !busy_o) begin
        if (cmd_i == CMD_PUSH) begin
          if (fmt == FMT_OFFSET) begin
            frame_re[fill] = int'(sample_i_i[7:0]) - 128;
            frame_im[fill] = int'(sample_q_i[7:0]) - 128;
          end else begin
            frame_re[fill] = int'(sample_i_i);
            frame_im[fill] = (fmt == FMT_REAL) ? 0 : int'(sample_q_i);
          end
          fill++;
          if (fill == FFT_SIZE) begin
            fill = 0;
            transform_frame();
            accumulate_power();
          end
        end else if (cmd_i == CMD_READ || cmd_i == CMD_READ_CLR) begin
          want.pos = read_index_i;
          want.pwr = power_acc[read_index_i];
          want.sat = sat_mark[read_index_i];
          bin_reads_q.push_back(want);
          if (cmd_i == CMD_READ_CLR) begin
            power_acc[read_index_i] = '0;
            sat_mark[read_index_i]  = 1'b0;
          end
        end
      end
    end
  end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import fpsa_pkg::*;

  localparam logic [1:0] CMD_NONE   = 2'd3;
  localparam logic [1:0] FMT_SPARE  = 2'd3;
  localparam int         STALL_MAX  = 200000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    start_i = 1'b0;
  logic                    busy_o;
  logic [1:0]              cmd_i = CMD_NONE;
  logic signed [SMP_W-1:0] sample_i_i = '0;
  logic signed [SMP_W-1:0] sample_q_i = '0;
  logic [IDX_W-1:0]        read_index_i = '0;
  logic                    cfg_we_i = 1'b0;
  logic [1:0]              cfg_wdata_i = FMT_OFFSET;
  logic                    valid_o;
  logic [IDX_W-1:0]        bin_position_o;
  logic [ACC_W-1:0]        power_o;
  logic                    saturated_o;
  int                      mismatches;
  int                      pending;
  int                      stall_cycles = 0;
  bit                      steady;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  fft_power_spectrum_accumulator dut (.*);

  tb_spectrum_checker checker_i (.*, .mismatches_o(mismatches), .pending_o(pending));

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_MAX) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic issue(logic [1:0] cmd, logic [15:0] si, logic [15:0] sq,
                       logic [IDX_W-1:0] idx);
    int gap;
    start_i      <= 1'b1;
    cmd_i        <= cmd;
    sample_i_i   <= si;
    sample_q_i   <= sq;
    read_index_i <= idx;
    do @(posedge clk_i); while (busy_o);
    if (steady) gap = 0;
    else if ($urandom_range(0, 11) == 0) gap = $urandom_range(12, 80);
    else if ($urandom_range(0, 2) == 0) gap = 0;
    else gap = $urandom_range(1, 3);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // The sender holds off until all reads are answered and the transform is done.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic set_format(logic [1:0] f);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= f;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'(int'($urandom_range(0, 255)));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    case ($urandom_range(0, 5))
      0: return IDX_W'(FFT_SIZE / 2 - 2 + $urandom_range(0, 3));
      1: return $urandom_range(0, 1) ? '0 : '1;
      default: return IDX_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [1:0] plan[7];
    int         roll;
    plan   = '{FMT_OFFSET, FMT_SIGNED, FMT_REAL, FMT_SPARE,
               FMT_SIGNED, FMT_OFFSET, FMT_SIGNED};
    steady = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty accumulator reads, clearing reads, ignored commands and the first pushes.
    issue(CMD_READ, 16'h0000, 16'h0000, '0);
    issue(CMD_READ, 16'hffff, 16'hffff, '1);
    issue(CMD_READ_CLR, 16'h0000, 16'h0000, IDX_W'(FFT_SIZE / 2));
    issue(CMD_READ_CLR, 16'h0000, 16'h0000, IDX_W'(FFT_SIZE / 2 - 1));
    issue(CMD_NONE, 16'hffff, 16'hffff, '1);
    issue(CMD_NONE, 16'h0000, 16'h0000, '0);
    issue(CMD_PUSH, 16'h7fff, 16'h8000, '1);
    issue(CMD_PUSH, 16'h8000, 16'h7fff, '0);
    issue(CMD_PUSH, 16'h00ff, 16'h0000, '0);
    issue(CMD_PUSH, 16'h0080, 16'hff80, '0);
    issue(CMD_PUSH, 16'hffff, 16'h0001, '0);

    foreach (plan[ph]) begin
      set_format(plan[ph]);
      steady = ($urandom_range(0, 2) == 0);
      for (int n = 0; n < 180; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 85) issue(CMD_PUSH, pick_sample(), pick_sample(), IDX_W'($urandom));
        else if (roll < 92) issue(CMD_READ, 16'($urandom), 16'($urandom), pick_index());
        else if (roll < 98) issue(CMD_READ_CLR, 16'($urandom), 16'($urandom), pick_index());
        else issue(CMD_NONE, 16'($urandom), 16'($urandom), IDX_W'($urandom));
      end
    end

    // Sweep every seventh position of the spectrum once, clearing some at random.
    drain();
    steady = 1'b0;
    for (int p = 0; p < FFT_SIZE; p += 7) begin
      issue(($urandom_range(0, 1) != 0) ? CMD_READ_CLR : CMD_READ, 16'h0, 16'h0, IDX_W'(p));
    end

    start_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

/* files.f */
rtl/fpsa_pkg.sv
rtl/fpsa_xram.sv
rtl/fpsa_acc_ram.sv
rtl/fpsa_bfly.sv
rtl/fpsa_pwr.sv
rtl/fft_power_spectrum_accumulator.sv
sim/tb_spectrum_checker.sv
sim/tb_top.sv
